FILE: design/assert_macros.svh
// Assertion macros shared by the debounce and click detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define BDC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define BDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define BDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/bdc_pkg.sv
// Package with types and constants of the button debounce and click detector.
`timescale 1ns / 1ps
package bdc_pkg;

	localparam int TIME_W      = 32;
	localparam int MS_W        = 16;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int CLICK_W     = 8;
	localparam int FIFO_DEPTH  = 4;

	localparam logic [CLICK_W-1:0] CLICK_LIMIT = 8'd2;
	localparam logic [CLICK_W-1:0] CLICK_MAX   = 8'd255;

	localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [MS_W-1:0] LONG_RST     = 16'd1000;
	localparam logic [MS_W-1:0] WINDOW_RST   = 16'd400;

	localparam logic [CFG_ADDR_W-1:0] CFG_WIRED_TO_HIGH    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_NORMALLY_CLOSED  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_MS      = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_MS    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_WINDOW_MS = 3'd4;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_LONG     = 3'd2,
		EV_RELEASED = 3'd3,
		EV_REPEAT   = 3'd4,
		EV_CLICK    = 3'd5,
		EV_DOUBLE   = 3'd6
	} bdc_event_t;

	typedef struct packed {
		logic       level;
		bdc_event_t event_res;
		logic       last;
	} bdc_res_t;

	typedef struct packed {
		logic     valid;
		logic     two;
		bdc_res_t r0;
		bdc_res_t r1;
	} bdc_push_t;

endpackage

FILE: design/bdc_ifs.sv
// Channel interfaces for samples, results and configuration writes.
`timescale 1ns / 1ps
interface bdc_in_if;
	logic                       valid;
	logic                       ready;
	logic                       pin_level;
	logic [bdc_pkg::TIME_W-1:0] now_ms;
	modport source (output valid, output pin_level, output now_ms, input ready);
	modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdc_out_if;
	logic       valid;
	logic       ready;
	logic       level;
	logic [2:0] event_res;
	logic       last;
	modport source (output valid, output level, output event_res, output last, input ready);
	modport sink (input valid, input level, input event_res, input last, output ready);
endinterface

interface bdc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bdc_pkg::CFG_ADDR_W-1:0] addr;
	logic [bdc_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

FILE: design/bdc_core.sv
// Input register, configuration registers, debounce state and event decision.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdc_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_pin_level,
	input  logic [bdc_pkg::TIME_W-1:0]     in_now_ms,
	input  logic                           cfg_valid,
	input  logic [bdc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bdc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           room,
	output bdc_pkg::bdc_push_t             push
);
	import bdc_pkg::*;

	logic              valid_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] now_s1;

	logic              wired_q;
	logic              nc_q;
	logic [MS_W-1:0]   debounce_q;
	logic [MS_W-1:0]   long_q;
	logic [MS_W-1:0]   window_q;

	logic               prev_q;
	logic               stable_q;
	logic [TIME_W-1:0]  since_q;
	logic [TIME_W-1:0]  press_q;
	logic [TIME_W-1:0]  release_q;
	logic [CLICK_W-1:0] click_q;

	logic               fire;
	logic               cur;
	logic               changed;
	logic               back;
	logic               stable_d;
	logic               settled;
	logic [TIME_W-1:0]  since_d;
	logic [TIME_W-1:0]  press_b;
	logic [TIME_W-1:0]  release_b;
	logic [TIME_W-1:0]  press_d;
	logic [TIME_W-1:0]  release_d;
	logic [CLICK_W-1:0] click_u;
	logic [CLICK_W-1:0] click_d;
	logic [TIME_W-1:0]  held;
	logic [TIME_W-1:0]  gap;
	logic               a_v;
	bdc_event_t         a_ev;
	logic               b_v;
	logic               k_v;
	bdc_event_t         k_ev;
	logic               pressed;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pin_s1 <= in_pin_level;
			now_s1 <= in_now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wired_q    <= 1'b0;
			nc_q       <= 1'b0;
			debounce_q <= DEBOUNCE_RST;
			long_q     <= LONG_RST;
			window_q   <= WINDOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				CFG_WIRED_TO_HIGH:    wired_q    <= cfg_data[0];
				CFG_NORMALLY_CLOSED:  nc_q       <= cfg_data[0];
				CFG_DEBOUNCE_MS:      debounce_q <= cfg_data;
				CFG_LONG_PRESS_MS:    long_q     <= cfg_data;
				CFG_REPEAT_WINDOW_MS: window_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cur       = pin_s1 ^ wired_q ^ nc_q;
		changed   = cur != prev_q;
		back      = !changed && (now_s1 < since_q);
		since_d   = (changed || back) ? now_s1 : since_q;
		press_b   = back ? now_s1 : press_q;
		release_b = back ? now_s1 : release_q;
		if (changed) begin
			stable_d = 1'b0;
		end else if (!back && ((now_s1 - since_q) > {16'd0, debounce_q})) begin
			stable_d = 1'b1;
		end else begin
			stable_d = stable_q;
		end
		settled   = !changed && stable_d;
		held      = now_s1 - press_b;
		click_u   = (click_q < CLICK_MAX) ? click_q + 8'd1 : click_q;
		press_d   = press_b;
		release_d = release_b;
		click_d   = click_q;
		a_v       = 1'b0;
		a_ev      = EV_NONE;
		b_v       = 1'b0;
		k_v       = 1'b0;
		k_ev      = EV_NONE;
		pressed   = 1'b0;
		if (settled) begin
			if (cur) begin
				if (press_b < release_b) begin
					pressed = 1'b1;
					click_d = click_u;
					press_d = now_s1;
					a_v     = 1'b1;
					a_ev    = EV_PRESSED;
				end else if (held > {16'd0, long_q}) begin
					a_v  = 1'b1;
					a_ev = EV_LONG;
				end
			end else if (press_b >= release_b) begin
				release_d = now_s1;
				a_v       = 1'b1;
				a_ev      = EV_RELEASED;
				b_v       = click_q > CLICK_LIMIT;
			end
			gap = pressed ? '0 : held;
			if (click_d != 8'd0 && gap > {16'd0, window_q}) begin
				if (click_d == 8'd1) begin
					k_v  = 1'b1;
					k_ev = EV_CLICK;
				end else if (click_d == CLICK_LIMIT) begin
					k_v  = 1'b1;
					k_ev = EV_DOUBLE;
				end
				click_d = 8'd0;
			end
		end else begin
			gap = held;
		end
	end

	always_comb begin
		push.valid        = fire;
		push.two          = a_v && (b_v || k_v);
		push.r0.level     = cur;
		push.r1.level     = cur;
		push.r0.event_res = a_v ? a_ev : (k_v ? k_ev : EV_NONE);
		push.r1.event_res = b_v ? EV_REPEAT : k_ev;
		push.r0.last      = !(a_v && (b_v || k_v));
		push.r1.last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			stable_q  <= 1'b0;
			since_q   <= '0;
			press_q   <= '0;
			release_q <= '0;
			click_q   <= '0;
		end else if (fire) begin
			prev_q    <= cur;
			stable_q  <= stable_d;
			since_q   <= since_d;
			press_q   <= press_d;
			release_q <= release_d;
			click_q   <= click_d;
		end
	end

	`BDC_ASSERT_IMPL(a_two_last, clk, arst_n, push.valid && push.two, !push.r0.last)
	`BDC_ASSERT_IMPL(a_press_level, clk, arst_n,
		push.valid && push.r0.event_res == EV_PRESSED, push.r0.level)
	`BDC_ASSERT_NEXT(a_change_unstable, clk, arst_n, fire && changed, !stable_q)

endmodule

FILE: design/bdc_out_fifo.sv
// Result queue: takes one or two results per cycle, sends one when ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdc_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  bdc_pkg::bdc_push_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output bdc_pkg::bdc_res_t  out_res
);
	import bdc_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	bdc_res_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic [CNT_W-1:0] n_push;
	logic [PTR_W-1:0] wr_nx;

	assign room      = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = push.valid ? (push.two ? CNT_W'(2) : CNT_W'(1)) : '0;
	assign wr_nx     = wr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.r0;
			if (push.two) begin
				mem_q[wr_nx] <= push.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[PTR_W-1:0];
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	`BDC_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(FIFO_DEPTH))
	`BDC_ASSERT_IMPL(a_push_room, clk, arst_n, push.valid, room)
	`BDC_ASSERT_NEXT(a_pop_count, clk, arst_n, pop && !push.valid,
		cnt_q == $past(cnt_q) - CNT_W'(1))

endmodule

FILE: design/button_debounce_click_detector_top.sv
// Top level of the button debounce and click detector.
`timescale 1ns / 1ps
// Usage: each transaction on in_ch carries one raw pin sample and its
// millisecond timestamp. For every sample the block sends one or two
// transactions on out_ch with the corrected level and an event code; the
// last flag marks the final one of the sample.
// Configuration writes arrive on cfg_ch, which is always ready; register
// addresses follow the register list. The user must see that registers are
// written only while idle; the block itself does not enforce this.
// A sample is taken into the input register, then decided and written into
// the result queue once it has room; the queue offers its results on out_ch.
// Throughput: one sample per cycle while each sample yields one result and
// the receiver is ready; two results of one sample share the single output
// port, so the output port sets the rate of one result per cycle.
// Reset clears the debounce state, the click count and the result queue,
// and loads the default delays.
// When the receiver stalls, up to four results wait in the queue and the
// input register holds one sample; in_ch then drops ready.
module button_debounce_click_detector_top (
	input  logic clk,
	input  logic arst_n,
	bdc_in_if.sink     in_ch,
	bdc_out_if.source  out_ch,
	bdc_cfg_if.sink    cfg_ch
);
	import bdc_pkg::*;

	logic      room;
	bdc_push_t push;
	bdc_res_t  res;

	assign cfg_ch.ready = 1'b1;

	bdc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_pin_level (in_ch.pin_level),
		.in_now_ms    (in_ch.now_ms),
		.cfg_valid    (cfg_ch.valid),
		.cfg_addr     (cfg_ch.addr),
		.cfg_data     (cfg_ch.data),
		.room         (room),
		.push         (push)
	);

	bdc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (res)
	);

	assign out_ch.level     = res.level;
	assign out_ch.event_res = res.event_res;
	assign out_ch.last      = res.last;

endmodule

FILE: dv/tb_button_debounce_click_detector_top.sv
// Self-checking testbench of the button debounce and click detector top level.
`timescale 1ns / 1ps

module tb_button_debounce_click_detector_top;
	import bdc_pkg::*;

	class click_scoreboard;
		logic        wiring_inv;
		logic        contact_inv;
		logic [15:0] debounce_len;
		logic [15:0] long_len;
		logic [15:0] window_len;

		logic        last_level;
		logic        is_settled;
		logic [31:0] settle_start;
		logic [31:0] press_stamp;
		logic [31:0] release_stamp;
		logic [7:0]  click_cnt;

		bdc_res_t expected_events[$];
		int errors;

		function new();
			wiring_inv = 1'b0;
			contact_inv = 1'b0;
			debounce_len = DEBOUNCE_RST;
			long_len = LONG_RST;
			window_len = WINDOW_RST;
			last_level = 1'b0;
			is_settled = 1'b0;
			settle_start = '0;
			press_stamp = '0;
			release_stamp = '0;
			click_cnt = '0;
			errors = 0;
		endfunction

		function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				CFG_WIRED_TO_HIGH: wiring_inv = data[0];
				CFG_NORMALLY_CLOSED: contact_inv = data[0];
				CFG_DEBOUNCE_MS: debounce_len = data;
				CFG_LONG_PRESS_MS: long_len = data;
				CFG_REPEAT_WINDOW_MS: window_len = data;
				default: ;
			endcase
		endfunction

		function void note_sample(logic pin, logic [31:0] stamp);
			bdc_event_t evs[$];
			logic       cur;
			bdc_res_t   r;
			int         n;
			cur = pin ^ wiring_inv ^ contact_inv;
			if (cur != last_level) begin
				is_settled = 1'b0;
				last_level = cur;
				settle_start = stamp;
			end else begin
				if (stamp < settle_start) begin
					settle_start = stamp;
					press_stamp = stamp;
					release_stamp = stamp;
				end else if (stamp - settle_start > {16'd0, debounce_len}) begin
					is_settled = 1'b1;
				end
				if (is_settled) begin
					if (cur) begin
						if (press_stamp < release_stamp) begin
							if (click_cnt != CLICK_MAX)
								click_cnt = click_cnt + 8'd1;
							evs.push_back(EV_PRESSED);
							press_stamp = stamp;
						end else if (stamp - press_stamp > {16'd0, long_len}) begin
							evs.push_back(EV_LONG);
						end
					end else if (press_stamp >= release_stamp) begin
						release_stamp = stamp;
						evs.push_back(EV_RELEASED);
						if (click_cnt > CLICK_LIMIT)
							evs.push_back(EV_REPEAT);
					end
					if (click_cnt != 8'd0 && stamp - press_stamp > {16'd0, window_len}) begin
						if (click_cnt == 8'd1)
							evs.push_back(EV_CLICK);
						else if (click_cnt == CLICK_LIMIT)
							evs.push_back(EV_DOUBLE);
						click_cnt = '0;
					end
				end
			end
			if (evs.size() == 0)
				evs.push_back(EV_NONE);
			n = (evs.size() > 2) ? 2 : evs.size();
			for (int k = 0; k < n; k++) begin
				r.level = cur;
				r.event_res = evs[k];
				r.last = (k == n - 1);
				expected_events.push_back(r);
			end
		endfunction

		function void check_result(logic lvl, logic [2:0] ev, logic lst);
			bdc_res_t exp_r;
			if (expected_events.size() == 0) begin
				$error("result with nothing expected: level %0b event_res %0d last %0b",
					lvl, ev, lst);
				errors++;
				return;
			end
			exp_r = expected_events.pop_front();
			if (lvl !== exp_r.level) begin
				$error("level: expected %0b, actual %0b", exp_r.level, lvl);
				errors++;
			end
			if (ev !== exp_r.event_res) begin
				$error("event_res: expected %0d, actual %0d", exp_r.event_res, ev);
				errors++;
			end
			if (lst !== exp_r.last) begin
				$error("last: expected %0b, actual %0b", exp_r.last, lst);
				errors++;
			end
		endfunction

		function int pending();
			return expected_events.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bdc_in_if  in_ch();
	bdc_out_if out_ch();
	bdc_cfg_if cfg_ch();

	click_scoreboard sb = new();

	logic        wiring_inv;
	logic        contact_inv;
	int unsigned deb_ms;
	int unsigned long_ms;
	int unsigned win_ms;
	logic [31:0] stamp_ms;
	int          samples_sent;
	int          burst_left;
	int          stall_left;
	int          stall_mode;

	button_debounce_click_detector_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(10, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			default: out_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_register(cfg_ch.addr, cfg_ch.data);
			if (in_ch.valid && in_ch.ready)
				sb.note_sample(in_ch.pin_level, in_ch.now_ms);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.level, out_ch.event_res, out_ch.last);
		end
	end

	function logic raw_pin(logic lvl);
		return lvl ^ wiring_inv ^ contact_inv;
	endfunction

	task automatic send_sample(logic pin, logic [31:0] stamp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_ch.valid <= 1'b1;
		in_ch.pin_level <= pin;
		in_ch.now_ms <= stamp;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		samples_sent++;
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= addr;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic wth, logic nc, logic [15:0] deb, logic [15:0] lp,
		logic [15:0] win);
		wait_idle();
		write_reg(CFG_WIRED_TO_HIGH, {15'd0, wth});
		write_reg(CFG_NORMALLY_CLOSED, {15'd0, nc});
		write_reg(CFG_DEBOUNCE_MS, deb);
		write_reg(CFG_LONG_PRESS_MS, lp);
		write_reg(CFG_REPEAT_WINDOW_MS, win);
		cfg_ch.valid <= 1'b0;
		wiring_inv = wth;
		contact_inv = nc;
		deb_ms = 32'(deb);
		long_ms = 32'(lp);
		win_ms = 32'(win);
	endtask

	task automatic hold_level(logic lvl, int unsigned dur);
		int          bounces;
		int unsigned n;
		bounces = $urandom_range(0, 2);
		for (int i = 0; i < bounces; i++) begin
			send_sample(raw_pin((i % 2) ? lvl : ~lvl), stamp_ms);
			stamp_ms = stamp_ms + $urandom_range(0, 2);
		end
		n = $urandom_range(2, 5);
		send_sample(raw_pin(lvl), stamp_ms);
		for (int k = 0; k < n; k++) begin
			stamp_ms = stamp_ms + dur / n + $urandom_range(0, 1);
			send_sample(raw_pin(lvl), stamp_ms);
		end
	endtask

	function int unsigned click_len();
		return deb_ms + 2 + $urandom_range(0, win_ms / 3 + 2);
	endfunction

	task automatic gesture();
		int          clicks;
		int          noise_n;
		logic [31:0] noise_stamp;
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				clicks = $urandom_range(1, 5);
				for (int c = 0; c < clicks; c++) begin
					hold_level(1'b1, click_len());
					hold_level(1'b0, click_len());
				end
				hold_level(1'b0, deb_ms + win_ms + $urandom_range(2, 50));
			end
			3: begin
				hold_level(1'b1, long_ms + deb_ms + $urandom_range(2, long_ms / 2 + 20));
				hold_level(1'b0, deb_ms + win_ms + $urandom_range(2, 20));
			end
			4: hold_level(1'($urandom_range(0, 1)), $urandom_range(0, deb_ms));
			default: begin
				noise_n = $urandom_range(1, 3);
				for (int i = 0; i < noise_n; i++) begin
					noise_stamp = $urandom;
					send_sample(1'($urandom_range(0, 1)), noise_stamp);
					if ($urandom_range(0, 1))
						stamp_ms = noise_stamp;
				end
			end
		endcase
	endtask

	initial begin
		int phase;
		int phase_end;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.pin_level = 1'b0;
		in_ch.now_ms = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
		wiring_inv = 1'b0;
		contact_inv = 1'b0;
		deb_ms = 32'(DEBOUNCE_RST);
		long_ms = 32'(LONG_RST);
		win_ms = 32'(WINDOW_RST);
		stamp_ms = '0;
		samples_sent = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(1'b0, 32'd0);
		send_sample(1'b0, 32'd100);
		send_sample(1'b1, 32'd110);
		send_sample(1'b1, 32'd200);
		send_sample(1'b1, 32'd1300);
		send_sample(1'b0, 32'd1310);
		send_sample(1'b0, 32'd1400);
		send_sample(1'b1, 32'd1410);
		send_sample(1'b1, 32'd1500);
		send_sample(1'b0, 32'd1510);
		send_sample(1'b0, 32'd1600);
		send_sample(1'b1, 32'd1610);
		send_sample(1'b1, 32'd1700);
		send_sample(1'b0, 32'd1710);
		send_sample(1'b0, 32'd1800);
		send_sample(1'b0, 32'd2200);
		send_sample(1'b1, 32'hFFFF_FFF0);
		send_sample(1'b1, 32'hFFFF_FFFF);
		send_sample(1'b1, 32'd0);
		send_sample(1'b1, 32'd60);

		set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'd0, 16'hFFFF,
			16'hFFFF);
		stamp_ms = $urandom_range(0, 32'h7FFF_FFFF);
		for (int c = 0; c < 262; c++) begin
			send_sample(raw_pin(1'b1), stamp_ms);
			stamp_ms = stamp_ms + $urandom_range(1, 3);
			send_sample(raw_pin(1'b1), stamp_ms);
			stamp_ms = stamp_ms + $urandom_range(1, 3);
			send_sample(raw_pin(1'b0), stamp_ms);
			stamp_ms = stamp_ms + $urandom_range(1, 3);
			send_sample(raw_pin(1'b0), stamp_ms);
			stamp_ms = stamp_ms + $urandom_range(1, 3);
		end
		stamp_ms = stamp_ms + 32'd70000;
		send_sample(raw_pin(1'b0), stamp_ms);

		phase = 0;
		while (samples_sent < 1650) begin
			case (phase % 6)
				0: set_config(phase[1], phase[2], 16'($urandom_range(0, 8)),
					16'($urandom_range(0, 60)), 16'($urandom_range(0, 40)));
				1: set_config(phase[1], phase[2], 16'd0, 16'd0, 16'd0);
				2: set_config(phase[1], phase[2], 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: set_config(phase[1], phase[2], 16'($urandom_range(0, 16'hFFFF)),
					16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
				4: set_config(phase[1], phase[2], 16'($urandom_range(0, 8)), 16'hFFFF,
					16'd0);
				default: set_config(phase[1], phase[2], 16'd0,
					16'($urandom_range(0, 60)), 16'hFFFF);
			endcase
			if ($urandom_range(0, 3) == 0)
				stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
			phase_end = samples_sent + $urandom_range(60, 110);
			while (samples_sent < phase_end)
				gesture();
			phase++;
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
